### hw/rtl/tcjl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcjl_pkg
// Shared widths, constants and voltage/temperature tables of the
// thermocouple cold-junction linearizer.
// ----------------------------------------------------------------------------
package tcjl_pkg;

  localparam int TABLE_POINTS_DEF = 16;
  localparam int ROM_DEPTH        = 64;
  localparam int ROM_IW           = 6;

  localparam int TAB_W    = 20;  // table entry, signed
  localparam int COLD_W   = 17;  // cold temperature, 1/128 degC
  localparam int TEMP_W   = 17;  // result temperature, 1/128 degC
  localparam int CPLV_W   = 24;  // couple voltage, 1/16 uV
  localparam int SUM_W    = 24;  // summed voltage, 1/16 uV
  localparam int PROD_W   = 32;  // interpolation product
  localparam int LERP_YW  = 22;  // interpolated value
  localparam int COLD_QW  = 18;  // quotient bits, temperature to voltage
  localparam int HOT_QW   = 14;  // quotient bits, voltage to temperature

  localparam logic signed [CPLV_W-1:0] CPL_SCALE = 24'sd125;

  function automatic logic signed [TAB_W-1:0] volt_at(input logic [ROM_IW-1:0] idx);
    logic signed [TAB_W-1:0] v;
    case (idx)
      6'd0:    v = 20'sd0;
      6'd1:    v = 20'sd5072;
      6'd2:    v = 20'sd27760;
      6'd3:    v = 20'sd34352;
      6'd4:    v = 20'sd47360;
      6'd5:    v = 20'sd50944;
      6'd6:    v = 20'sd54256;
      6'd7:    v = 20'sd60896;
      6'd8:    v = 20'sd65520;
      6'd9:    v = 20'sd74128;
      6'd10:   v = 20'sd96928;
      6'd11:   v = 20'sd141760;
      6'd12:   v = 20'sd188800;
      6'd13:   v = 20'sd235840;
      6'd14:   v = 20'sd283200;
      6'd15:   v = 20'sd330240;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic signed [TAB_W-1:0] temp_at(input logic [ROM_IW-1:0] idx);
    logic signed [TAB_W-1:0] t;
    case (idx)
      6'd0:    t = 20'sd0;
      6'd1:    t = 20'sd1024;
      6'd2:    t = 20'sd5504;
      6'd3:    t = 20'sd7424;
      6'd4:    t = 20'sd9294;
      6'd5:    t = 20'sd9984;
      6'd6:    t = 20'sd10624;
      6'd7:    t = 20'sd11904;
      6'd8:    t = 20'sd12800;
      6'd9:    t = 20'sd14464;
      6'd10:   t = 20'sd18944;
      6'd11:   t = 20'sd27903;
      6'd12:   t = 20'sd37139;
      6'd13:   t = 20'sd46162;
      6'd14:   t = 20'sd55140;
      6'd15:   t = 20'sd64000;
      default: t = '0;
    endcase
    return t;
  endfunction

endpackage

### hw/rtl/tcjl_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcjl_div
// Pipelined restoring divider, one quotient bit per stage, with a side tag
// that travels alongside each item.
// ----------------------------------------------------------------------------
module tcjl_div #(
  parameter int AW = 33,
  parameter int DW = 21,
  parameter int QW = 18,
  parameter int TW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_v,
  input  logic [AW-1:0] in_num,
  input  logic [DW-1:0] in_den,
  input  logic [TW-1:0] in_tag,
  output logic          out_v,
  output logic [QW-1:0] out_q,
  output logic [TW-1:0] out_tag
);

  localparam int RW = (AW > DW + QW) ? AW : DW + QW;

  logic [RW-1:0] rem [0:QW];
  logic [DW-1:0] den [0:QW];
  logic [QW-1:0] quo [0:QW];
  logic [TW-1:0] tag [0:QW];
  logic          vld [0:QW];

  assign rem[0] = RW'(in_num);
  assign den[0] = in_den;
  assign quo[0] = '0;
  assign tag[0] = in_tag;
  assign vld[0] = in_v;

  for (genvar s = 0; s < QW; s++) begin : g_stage
    localparam int K = QW - 1 - s;
    logic [RW-1:0] trial;
    logic          take;

    always_comb begin
      trial = RW'(den[s]) << K;
      take  = rem[s] >= trial;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else begin
        vld[s+1] <= vld[s];
      end
      rem[s+1] <= take ? rem[s] - trial : rem[s];
      den[s+1] <= den[s];
      quo[s+1] <= quo[s] | (QW'(take) << K);
      tag[s+1] <= tag[s];
    end
  end

  assign out_v   = vld[QW];
  assign out_q   = quo[QW];
  assign out_tag = tag[QW];

endmodule

### hw/rtl/tcjl_lerp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcjl_lerp
// Piecewise-linear table lookup: segment search, table fetch, multiply,
// magnitudes and rounding bias, divider stages and offset add, all registered.
// ----------------------------------------------------------------------------
module tcjl_lerp #(
  parameter int NPTS = tcjl_pkg::TABLE_POINTS_DEF,
  parameter int XW   = tcjl_pkg::COLD_W,
  parameter int QW   = tcjl_pkg::COLD_QW,
  parameter int YW   = tcjl_pkg::LERP_YW,
  parameter int TW   = 8,
  parameter bit FWD  = 1'b1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_v,
  input  logic signed [XW-1:0] in_x,
  input  logic [TW-1:0]        in_tag,
  output logic                 out_v,
  output logic signed [YW-1:0] out_y,
  output logic [TW-1:0]        out_tag
);

  localparam int TVW = tcjl_pkg::TAB_W;
  localparam int RIW = tcjl_pkg::ROM_IW;
  localparam int IW  = $clog2(NPTS);
  localparam int DXW = ((XW > TVW) ? XW : TVW) + 1;
  localparam int DYW = TVW + 1;
  localparam int PW  = tcjl_pkg::PROD_W;
  localparam int AW  = PW + 1;
  localparam int SDW = TVW + 2 + TW;
  localparam int YIW = ((TVW > QW + 1) ? TVW : QW + 1) + 1;

  function automatic logic signed [TVW-1:0] xtab(input logic [RIW-1:0] i);
    return FWD ? tcjl_pkg::temp_at(i) : tcjl_pkg::volt_at(i);
  endfunction

  function automatic logic signed [TVW-1:0] ytab(input logic [RIW-1:0] i);
    return FWD ? tcjl_pkg::volt_at(i) : tcjl_pkg::temp_at(i);
  endfunction

  // segment search
  logic                 v1;
  logic signed [XW-1:0] x1;
  logic [IW-1:0]        seg1;
  logic [IW-1:0]        seg1_next;
  logic [TW-1:0]        tag1;

  always_comb begin
    int sel;
    sel = NPTS;
    for (int i = NPTS - 1; i >= 0; i--) begin
      if (DXW'(xtab(RIW'(i))) >= DXW'(in_x)) sel = i;
    end
    if (sel > NPTS - 1) sel = NPTS - 1;
    if (sel < 1) sel = 1;
    seg1_next = IW'(sel);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= in_v;
    end
    x1   <= in_x;
    seg1 <= seg1_next;
    tag1 <= in_tag;
  end

  // table fetch
  logic                  v2;
  logic signed [DXW-1:0] dx2;
  logic signed [DYW-1:0] dy2;
  logic signed [DYW-1:0] den2;
  logic signed [TVW-1:0] y02;
  logic [TW-1:0]         tag2;
  logic [RIW-1:0]        i_hi;
  logic [RIW-1:0]        i_lo;

  always_comb begin
    i_hi = RIW'(seg1);
    i_lo = i_hi - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    dx2  <= DXW'(x1) - DXW'(xtab(i_lo));
    dy2  <= DYW'(ytab(i_hi)) - DYW'(ytab(i_lo));
    den2 <= DYW'(xtab(i_hi)) - DYW'(xtab(i_lo));
    y02  <= ytab(i_lo);
    tag2 <= tag1;
  end

  // multiply
  logic                      v3;
  logic signed [DXW+DYW-1:0] full;
  logic signed [PW-1:0]      prod3;
  logic signed [DYW-1:0]     den3;
  logic signed [TVW-1:0]     y03;
  logic [TW-1:0]             tag3;

  always_comb begin
    full = dy2 * dx2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    prod3 <= $signed(full[PW-1:0]);
    den3  <= den2;
    y03   <= y02;
    tag3  <= tag2;
  end

  // magnitudes and rounding bias
  logic           v4;
  logic [PW-1:0]  amag;
  logic [DYW-1:0] bmag;
  logic [AW-1:0]  num4;
  logic [DYW-1:0] bmag4;
  logic [SDW-1:0] side4;

  always_comb begin
    amag = prod3[PW-1] ? unsigned'(-prod3) : unsigned'(prod3);
    bmag = den3[DYW-1] ? unsigned'(-den3) : unsigned'(den3);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= v3;
    end
    num4  <= AW'(amag) + AW'(bmag >> 1);
    bmag4 <= bmag;
    side4 <= {y03, prod3[PW-1] ^ den3[DYW-1], den3 == '0, tag3};
  end

  // divide
  logic           dv;
  logic [QW-1:0]  dq;
  logic [SDW-1:0] dside;

  tcjl_div #(
    .AW (AW),
    .DW (DYW),
    .QW (QW),
    .TW (SDW)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .in_v    (v4),
    .in_num  (num4),
    .in_den  (bmag4),
    .in_tag  (side4),
    .out_v   (dv),
    .out_q   (dq),
    .out_tag (dside)
  );

  // offset add
  logic signed [TVW-1:0] dy0;
  logic                  dneg;
  logic                  dzero;
  logic signed [YIW-1:0] qs;
  logic signed [YIW-1:0] ysum;

  always_comb begin
    dy0   = $signed(dside[SDW-1:TW+2]);
    dneg  = dside[TW+1];
    dzero = dside[TW];
    qs    = YIW'($signed({1'b0, dq}));
    if (dneg) qs = -qs;
    ysum = YIW'(dy0) + qs;
    if (dzero) ysum = YIW'(dy0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else begin
      out_v <= dv;
    end
    out_y   <= YW'(ysum);
    out_tag <= dside[TW-1:0];
  end

endmodule

### hw/rtl/thermocouple_cold_junction_linearizer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thermocouple_cold_junction_linearizer_core
// Cold-junction compensated thermocouple linearizer: cold temperature to
// equivalent voltage, add couple voltage, voltage back to temperature.
//
//   channel  ports                              handshake
//   -------  ---------------------------------  ----------------------------
//   input    cold_code, couple_code             start && !busy
//   result   temperature, out_of_table          done, one cycle per item
//
// One item enters per cycle; its result passes the decode register, two
// table lookups (search, fetch, multiply, rounding-bias, one-bit-per-stage
// divider of 18 or 14 stages, offset add), couple add and result select.
// busy is high only during reset; rst is synchronous and clears all valid
// bits. The receiver cannot stall, so the pipeline never holds.
// ----------------------------------------------------------------------------
module thermocouple_cold_junction_linearizer_core #(
  parameter int TABLE_POINTS = tcjl_pkg::TABLE_POINTS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [15:0]                         cold_code,
  input  logic signed [15:0]                  couple_code,
  output logic                                done,
  output logic signed [tcjl_pkg::TEMP_W-1:0]  temperature,
  output logic                                out_of_table
);

  localparam int NPTS = (TABLE_POINTS < 2) ? 2 :
                        (TABLE_POINTS > tcjl_pkg::ROM_DEPTH) ? tcjl_pkg::ROM_DEPTH :
                        TABLE_POINTS;
  localparam int COLD_W = tcjl_pkg::COLD_W;
  localparam int CPLV_W = tcjl_pkg::CPLV_W;
  localparam int SUM_W  = tcjl_pkg::SUM_W;
  localparam int YW     = tcjl_pkg::LERP_YW;
  localparam int RIW    = tcjl_pkg::ROM_IW;
  localparam int CTW    = COLD_W + CPLV_W;
  localparam int HTW    = COLD_W + 1;
  localparam int LAT    = 13 + tcjl_pkg::COLD_QW + tcjl_pkg::HOT_QW;

  assign busy = rst;

  // decode inputs
  logic                     a_v;
  logic signed [COLD_W-1:0] a_cold;
  logic signed [CPLV_W-1:0] a_couple;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
    end else begin
      a_v <= start;
    end
    a_cold   <= $signed({cold_code[15], cold_code[15:2], 2'b00});
    a_couple <= CPLV_W'(couple_code) * tcjl_pkg::CPL_SCALE;
  end

  // cold temperature to voltage
  logic                 c_v;
  logic signed [YW-1:0] c_y;
  logic [CTW-1:0]       c_tag;

  tcjl_lerp #(
    .NPTS (NPTS),
    .XW   (COLD_W),
    .QW   (tcjl_pkg::COLD_QW),
    .YW   (YW),
    .TW   (CTW),
    .FWD  (1'b1)
  ) u_cold (
    .clk     (clk),
    .rst     (rst),
    .in_v    (a_v),
    .in_x    (a_cold),
    .in_tag  ({a_cold, a_couple}),
    .out_v   (c_v),
    .out_y   (c_y),
    .out_tag (c_tag)
  );

  // add couple voltage, range check
  logic                     b_v;
  logic signed [SUM_W-1:0]  b_sum;
  logic signed [SUM_W-1:0]  b_sum_next;
  logic signed [COLD_W-1:0] b_cold;
  logic                     b_flag;

  always_comb begin
    b_sum_next = SUM_W'(c_y) + SUM_W'($signed(c_tag[CPLV_W-1:0]));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_v <= 1'b0;
    end else begin
      b_v <= c_v;
    end
    b_sum  <= b_sum_next;
    b_cold <= $signed(c_tag[CTW-1:CPLV_W]);
    b_flag <= (b_sum_next <= SUM_W'(tcjl_pkg::volt_at(RIW'(0)))) ||
              (b_sum_next > SUM_W'(tcjl_pkg::volt_at(RIW'(NPTS - 1))));
  end

  // voltage to hot temperature
  logic                 h_v;
  logic signed [YW-1:0] h_y;
  logic [HTW-1:0]       h_tag;

  tcjl_lerp #(
    .NPTS (NPTS),
    .XW   (SUM_W),
    .QW   (tcjl_pkg::HOT_QW),
    .YW   (YW),
    .TW   (HTW),
    .FWD  (1'b0)
  ) u_hot (
    .clk     (clk),
    .rst     (rst),
    .in_v    (b_v),
    .in_x    (b_sum),
    .in_tag  ({b_cold, b_flag}),
    .out_v   (h_v),
    .out_y   (h_y),
    .out_tag (h_tag)
  );

  // select result
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= h_v;
    end
    temperature  <= h_tag[0] ? $signed(h_tag[HTW-1:1])
                             : $signed(h_y[tcjl_pkg::TEMP_W-1:0]);
    out_of_table <= h_tag[0];
  end

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LAT done)
    else $error("item accepted without result at fixed latency");

  a_no_extra: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("result without matching item");

  a_cold_pass: assert property (@(posedge clk) disable iff (rst)
    (done && out_of_table) |->
      (temperature == $signed({$past(cold_code[15], LAT), $past(cold_code[15:2], LAT), 2'b00})))
    else $error("out-of-table result differs from cold temperature");

  a_in_range: assert property (@(posedge clk) disable iff (rst)
    (done && !out_of_table) |-> !temperature[tcjl_pkg::TEMP_W-1])
    else $error("in-table result below zero");

endmodule
